@@ design/brzc_pkg.sv @@
//------------------------------------------------------------------------------
// brzc_pkg
// Types and constants shared by the block RMS / zero-crossing meter.
//------------------------------------------------------------------------------
package brzc_pkg;

	localparam int SUM_W = 43;
	localparam int CNT_W = 13;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] rms_level;
		logic [11:0] crossings;
		logic [16:0] frequency_hz;
		logic [23:0] volume_average;
		logic [24:0] pitch_average;
	} out_item_t;

	// register indexes
	localparam logic [1:0] REG_RATE   = 2'd0;
	localparam logic [1:0] REG_VALPHA = 2'd1;
	localparam logic [1:0] REG_PALPHA = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accum;     // take sample into block accumulators
		logic load;      // latch closed block, start end-of-block work
		logic div_step;  // one restoring-division / root step
		logic mult;      // latch root and hz results
		logic smooth_v;  // update volume average
		logic smooth_p;  // update pitch average
		logic emit;      // move result to output register
	} brzc_cmd_t;

	typedef struct packed {
		logic closes;    // accepted sample closes the block
		logic step_done; // last iteration step
	} brzc_sts_t;

endpackage

@@ design/block_rms_zero_crossing_meter.sv @@
//------------------------------------------------------------------------------
// block_rms_zero_crossing_meter
// Block RMS level and zero-crossing pitch meter with smoothed averages.
//------------------------------------------------------------------------------
// Input transactions carry one signed sample and a last flag; one sample is
// taken per cycle while a block accumulates. A sample flagged last, or the
// MAX_BLOCK-th sample, closes the block and produces one output transaction.
// After a closing sample the input stalls while the bit-serial units run 43
// steps of sum/N (hz = crossings*rate/2N in steps 1..32 alongside) and 16 root
// steps, then the result latch, the volume and pitch smoothing and the output load.
// The result waits in the output register; the next block starts once it is
// loaded, so a stalled receiver only blocks after the following block closes.
// Reset clears the accumulators and averages and loads the register defaults
// (rate 44100, volume alpha 6554, pitch alpha 3277). The user writes registers
// over the APB port (0x0, 0x4, 0x8) only while idle; the block does not enforce it.
//------------------------------------------------------------------------------
module block_rms_zero_crossing_meter #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  brzc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output brzc_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import brzc_pkg::*;

	logic [17:0] rate_q;
	logic [15:0] valpha_q, palpha_q;
	brzc_cmd_t   cmd;
	brzc_sts_t   sts;
	logic [1:0]  ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 18'd44100; valpha_q <= 16'd6554; palpha_q <= 16'd3277;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_RATE:   rate_q   <= pwdata[17:0];
				REG_VALPHA: valpha_q <= pwdata[15:0];
				REG_PALPHA: palpha_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_RATE:   prdata = {14'd0, rate_q};
			REG_VALPHA: prdata = {16'd0, valpha_q};
			REG_PALPHA: prdata = {16'd0, palpha_q};
			default:    prdata = '0;
		endcase
	end

	brzc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.in_item(in_data), .sts, .cmd
	);

	brzc_dp #(.MAX_BLOCK(MAX_BLOCK)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .sts,
		.sample_rate(rate_q), .volume_alpha(valpha_q), .pitch_alpha(palpha_q),
		.out_item(out_data)
	);

endmodule

@@ design/brzc_ctrl.sv @@
//------------------------------------------------------------------------------
// brzc_ctrl
// Sequencer for end-of-block arithmetic and the output handshake.
//------------------------------------------------------------------------------
module brzc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  brzc_pkg::in_item_t  in_item,
	input  brzc_pkg::brzc_sts_t sts,
	output brzc_pkg::brzc_cmd_t cmd
);
	import brzc_pkg::*;

	localparam logic [2:0] S_ACC  = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SMV  = 3'd3;
	localparam logic [2:0] S_SMP  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic       ovalid_q;
	logic       acc;

	assign in_ready  = (state_q == S_ACC);
	assign out_valid = ovalid_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.accum    = acc;
		cmd.load     = acc && sts.closes;
		cmd.div_step = (state_q == S_DIV);
		cmd.mult     = (state_q == S_MUL);
		cmd.smooth_v = (state_q == S_SMV);
		cmd.smooth_p = (state_q == S_SMP);
		cmd.emit     = (state_q == S_EMIT) && (!ovalid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_ACC;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_ACC:  if (cmd.load) state_q <= S_DIV;
				S_DIV:  if (sts.step_done) state_q <= S_MUL;
				S_MUL:  state_q <= S_SMV;
				S_SMV:  state_q <= S_SMP;
				S_SMP:  state_q <= S_EMIT;
				S_EMIT: if (cmd.emit) state_q <= S_ACC;
				default: state_q <= S_ACC;
			endcase
		end
	end

	logic unused_in;
	assign unused_in = ^in_item;

endmodule

@@ design/brzc_dp.sv @@
//------------------------------------------------------------------------------
// brzc_dp
// Accumulators, iterative dividers and root unit, smoothing filters.
//------------------------------------------------------------------------------
module brzc_dp #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brzc_pkg::in_item_t   in_item,
	input  brzc_pkg::brzc_cmd_t  cmd,
	output brzc_pkg::brzc_sts_t  sts,
	input  logic [17:0]          sample_rate,
	input  logic [15:0]          volume_alpha,
	input  logic [15:0]          pitch_alpha,
	output brzc_pkg::out_item_t  out_item
);
	import brzc_pkg::*;

	localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BLOCK);
	// 43 quotient bits, 32 for hz, then 16 root steps after the 43 division iterations
	localparam int ITER = 43;

	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [11:0]        xc_q;
	logic signed [15:0] prev_q;
	logic [15:0]        mag;
	logic [31:0]        sq;
	logic [CNT_W-1:0]   cnt_nx;
	logic               xing;

	assign mag    = in_item.sample[15] ? 16'(-in_item.sample) : in_item.sample;
	assign sq     = mag * mag;
	assign cnt_nx = cnt_q + 1'b1;
	assign xing   = (cnt_q != '0) &&
		((prev_q > 0 && in_item.sample < 0) || (prev_q < 0 && in_item.sample > 0));
	assign sts.closes = in_item.last || (cnt_nx >= MAXB);

	// end-of-block registers
	logic [SUM_W-1:0]  dq_q;   // sum quotient shifted in
	logic [SUM_W-1:0]  drem_q;
	logic [SUM_W-1:0]  sdiv_q; // dividend being shifted out
	logic [CNT_W-1:0]  n_q;
	logic [11:0]       xcb_q;
	logic [5:0]        it_q;
	logic [31:0]       hq_q, hrem_q, hnum_q;   // crossings*rate / 2N
	logic [15:0]       root_q;
	logic [17:0]       rrem_q;
	logic [16:0]       hz_q;
	logic [23:0]       vol_q;
	logic [24:0]       pit_q;
	logic [15:0]       rms_q;
	logic [29:0]       prod_q;

	logic [SUM_W-1:0] dtry;
	logic [31:0]      htry;
	logic [CNT_W:0]   n2;
	assign n2   = {n_q, 1'b0};
	assign dtry = {drem_q[SUM_W-2:0], sdiv_q[SUM_W-1]};
	assign htry = {hrem_q[30:0], hnum_q[31]};

	// restoring root on the quotient, 2 bits a step over its low 32 bits
	logic [5:0]  rk;
	logic [17:0] rtry, rsub;
	logic [31:0] qv;
	assign qv   = dq_q[31:0];
	assign rk   = it_q - 6'(ITER);
	assign rtry = {rrem_q[15:0], qv[6'd31 - {rk[4:0], 1'b0} -: 2]};
	assign rsub = {root_q, 2'b01};
	assign sts.step_done = (it_q == 6'(ITER + 16 - 1));

	// smoothing
	logic signed [26:0] dv;
	logic signed [43:0] pv;
	logic signed [27:0] qsm;
	always_comb begin
		if (cmd.smooth_v) dv = 27'(signed'({1'b0, rms_q, 8'd0})) - 27'(signed'({1'b0, vol_q}));
		else              dv = 27'(signed'({1'b0, hz_q, 8'd0})) - 27'(signed'({1'b0, pit_q}));
		pv  = (cmd.smooth_v ? 44'(signed'({1'b0, volume_alpha}))
		                    : 44'(signed'({1'b0, pitch_alpha}))) * 44'(dv);
		qsm = 28'(pv >>> 16); // arithmetic shift floors
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0; cnt_q <= '0; xc_q <= '0; prev_q <= '0;
			vol_q <= '0; pit_q <= '0;
		end else begin
			if (cmd.accum) begin
				if (cmd.load) begin
					sum_q <= '0; cnt_q <= '0; xc_q <= '0; prev_q <= '0;
				end else begin
					sum_q  <= sum_q + SUM_W'(sq);
					cnt_q  <= cnt_nx;
					prev_q <= in_item.sample;
					if (xing && xc_q != 12'hFFF) xc_q <= xc_q + 1'b1;
				end
			end
			if (cmd.smooth_v) vol_q <= 24'(28'(signed'({1'b0, vol_q})) + qsm);
			if (cmd.smooth_p) pit_q <= 25'(28'(signed'({1'b0, pit_q})) + qsm);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sdiv_q <= sum_q + SUM_W'(sq);
			n_q    <= cnt_nx;
			xcb_q  <= (xing && xc_q != 12'hFFF) ? xc_q + 1'b1 : xc_q;
			drem_q <= '0; dq_q <= '0; it_q <= '0;
			root_q <= '0; rrem_q <= '0;
		end else if (cmd.div_step) begin
			it_q <= it_q + 1'b1;
			if (it_q == 6'd0) begin
				hnum_q <= 32'(xcb_q) * 32'(sample_rate);
				hrem_q <= '0;
			end
			if (it_q < 6'(ITER)) begin
				sdiv_q <= {sdiv_q[SUM_W-2:0], 1'b0};
				if (dtry >= SUM_W'(n_q)) begin
					drem_q <= dtry - SUM_W'(n_q); dq_q <= {dq_q[SUM_W-2:0], 1'b1};
				end else begin
					drem_q <= dtry; dq_q <= {dq_q[SUM_W-2:0], 1'b0};
				end
			end
			if (it_q >= 6'd1 && it_q <= 6'd32) begin
				hnum_q <= {hnum_q[30:0], 1'b0};
				if (htry >= 32'(n2)) begin
					hrem_q <= htry - 32'(n2); hq_q <= {hq_q[30:0], 1'b1};
				end else begin
					hrem_q <= htry; hq_q <= {hq_q[30:0], 1'b0};
				end
			end
			if (it_q >= 6'(ITER)) begin
				if (rtry >= rsub) begin
					rrem_q <= rtry - rsub; root_q <= {root_q[14:0], 1'b1};
				end else begin
					rrem_q <= rtry; root_q <= {root_q[14:0], 1'b0};
				end
			end
		end
		if (cmd.mult) begin
			rms_q  <= root_q;
			hz_q   <= hq_q[16:0];
			prod_q <= 30'(hq_q);
		end
		if (cmd.emit) begin
			out_item.rms_level      <= rms_q;
			out_item.crossings      <= xcb_q;
			out_item.frequency_hz   <= hz_q;
			out_item.volume_average <= vol_q;
			out_item.pitch_average  <= pit_q;
		end
	end

	logic unused_dp;
	assign unused_dp = ^prod_q ^ ^dq_q[SUM_W-1:32] ^ rrem_q[17];

endmodule

@@ design/brzc_checker.sv @@
//------------------------------------------------------------------------------
// brzc_checker
// Port-level checks for the block RMS / zero-crossing meter.
//------------------------------------------------------------------------------
module brzc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input brzc_pkg::in_item_t  in_data,
	input brzc_pkg::out_item_t out_data,
	input logic                pready
);
	import brzc_pkg::*;

	// a closing sample stalls the input on the next cycle
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last |=> !in_ready)
		else $error("input not stalled after closing sample");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// frequency fits its 17-bit field and rms_level does not exceed 32768
	a_hz_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frequency_hz <= 17'd131071 && out_data.rms_level <= 16'd32768)
		else $error("result out of range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind block_rms_zero_crossing_meter brzc_checker u_brzc_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.in_data, .out_data, .pready
);

@@ tb/sv/testbench.sv @@
//------------------------------------------------------------------------------
// testbench
// Block RMS / zero-crossing meter: drives sample blocks with random gaps and
// output stalls, predicts each block result and compares every output field.
//------------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import brzc_pkg::*;

	localparam int MAXB = 4096;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	block_rms_zero_crossing_meter #(.MAX_BLOCK(MAXB)) DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [17:0] rate_q = 18'd44100;
	logic [15:0] valpha_q = 16'd6554;
	logic [15:0] palpha_q = 16'd3277;
	logic [42:0] sq_sum = '0;
	logic [12:0] n_samp = '0;
	logic [11:0] n_cross = '0;
	logic signed [15:0] prev_s = '0;
	logic [23:0] vol_avg = '0;
	logic [24:0] pit_avg = '0;

	in_item_t pending_samples[$];
	out_item_t expected_blocks[$];
	int errors = 0;
	longint cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	bit driving = 1'b0;

	function automatic longint smooth_avg(longint old, longint target, longint alpha);
		longint p;
		longint q;
		p = alpha * (target - old);
		if (p >= 0) q = p >>> 16;
		else q = -((-p + 65535) >>> 16);
		return old + q;
	endfunction

	function automatic longint root_floor(longint v);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= v) r = r + 1;
		return r;
	endfunction

	task automatic predict_block(in_item_t it);
		longint mag;
		longint rms;
		longint hz;
		out_item_t o;
		if (n_samp > 0 && ((prev_s > 0 && it.sample < 0) || (prev_s < 0 && it.sample > 0)))
			if (n_cross < 12'd4095) n_cross = n_cross + 1;
		mag = it.sample < 0 ? -longint'(it.sample) : longint'(it.sample);
		sq_sum = sq_sum + 43'(mag * mag);
		n_samp = n_samp + 1;
		prev_s = it.sample;
		if (!it.last && n_samp < MAXB) return;
		rms = root_floor(longint'(sq_sum) / longint'(n_samp));
		hz = (longint'(n_cross) * longint'(rate_q)) / (2 * longint'(n_samp));
		vol_avg = 24'(smooth_avg(vol_avg, rms * 256, valpha_q));
		pit_avg = 25'(smooth_avg(pit_avg, hz * 256, palpha_q));
		o.rms_level = 16'(rms);
		o.crossings = n_cross;
		o.frequency_hz = 17'(hz);
		o.volume_average = vol_avg;
		o.pitch_average = pit_avg;
		expected_blocks.push_back(o);
		sq_sum = '0;
		n_samp = '0;
		n_cross = '0;
		prev_s = '0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_ready) predict_block(in_data);
		if (!in_valid || in_ready) begin
			if (driving && pending_samples.size() > 0 && gap_left == 0) begin
				in_data <= pending_samples.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left = gap_left - 1;
			end
		end
	end

	// monitor and output stall pattern
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				out_item_t e;
				e = expected_blocks.pop_front();
				if (out_data.rms_level !== e.rms_level)
					report_mismatch("rms_level", out_data.rms_level, e.rms_level);
				if (out_data.crossings !== e.crossings)
					report_mismatch("crossings", out_data.crossings, e.crossings);
				if (out_data.frequency_hz !== e.frequency_hz)
					report_mismatch("frequency_hz", out_data.frequency_hz, e.frequency_hz);
				if (out_data.volume_average !== e.volume_average)
					report_mismatch("volume_average", out_data.volume_average,
						e.volume_average);
				if (out_data.pitch_average !== e.pitch_average)
					report_mismatch("pitch_average", out_data.pitch_average,
						e.pitch_average);
			end
		end
		stall_phase <= (stall_phase + 1) % 256;
		if (stall_phase < 96) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 2) != 0) ? 1'b1 : ($urandom_range(0, 7) == 0 && stall_phase > 200 ? 1'b0 : 1'b0);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RATE: rate_q = val[17:0];
			REG_VALPHA: valpha_q = val[15:0];
			default: palpha_q = val[15:0];
		endcase
	endtask

	task automatic push_sample(logic signed [15:0] s, logic l);
		in_item_t it;
		it.sample = s;
		it.last = l;
		pending_samples.push_back(it);
	endtask

	// let the queued samples drain and the block finish its results
	task automatic drain_phase();
		driving = 1'b1;
		while (pending_samples.size() > 0 || in_valid) @(posedge clk);
		repeat (4) @(posedge clk);
		while (expected_blocks.size() > 0) @(posedge clk);
		driving = 1'b0;
		repeat (100) @(posedge clk);
	endtask

	task automatic random_blocks(int count);
		int len;
		int kind;
		for (int b = 0; b < count; b++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
			kind = $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				logic signed [15:0] s;
				case (kind)
					0: s = 16'($urandom);
					1: s = (i % 2) ? 16'sd30000 - 16'($urandom_range(0, 500))
						: -16'sd30000 + 16'($urandom_range(0, 500));
					2: s = 16'($urandom_range(0, 4)) - 16'sd2;
					default: s = (i % 3 == 0) ? 16'sd0 : 16'($urandom);
				endcase
				push_sample(s, i == len - 1);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed: extremes, zero breaking a crossing, single-sample block
		push_sample(16'sh7fff, 1'b0);
		push_sample(-16'sd32768, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(-16'sd1, 1'b1);
		push_sample(-16'sd32768, 1'b1);
		push_sample(16'sd5, 1'b1);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd0, 1'b1);
		push_sample(16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b1);
		drain_phase();
		// full block closes itself; alternating signs saturate the count
		for (int i = 0; i < MAXB; i++)
			push_sample((i % 2) ? -16'sd32768 : 16'sh7fff, 1'b0);
		push_sample(16'sd7, 1'b1);
		drain_phase();
		apb_write(REG_RATE, 32'd192000);
		apb_write(REG_VALPHA, 32'd65535);
		apb_write(REG_PALPHA, 32'd0);
		random_blocks(35);
		drain_phase();
		apb_write(REG_RATE, 32'd8000);
		apb_write(REG_VALPHA, 32'd0);
		apb_write(REG_PALPHA, 32'd65535);
		random_blocks(35);
		drain_phase();
		apb_write(REG_RATE, 32'($urandom_range(8000, 192000)));
		apb_write(REG_VALPHA, 32'($urandom_range(0, 65535)));
		apb_write(REG_PALPHA, 32'($urandom_range(0, 65535)));
		random_blocks(20);
		drain_phase();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

@@ files.f @@
design/brzc_pkg.sv
design/brzc_ctrl.sv
design/brzc_dp.sv
design/block_rms_zero_crossing_meter.sv
design/brzc_checker.sv
tb/sv/testbench.sv
